// ===== hw/rtl/tom_pkg.sv =====
// ----------------------------------------------------------------------------
// tom_pkg: shared types and constants for the tile occlusion map
// Command codes, register indexes, controller state, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tom_pkg;

	// map geometry defaults (tiles)
	localparam int TOM_MAP_COLS = 96;
	localparam int TOM_MAP_ROWS = 64;

	// field widths
	localparam int TOM_COORD_W = 16;
	localparam int TOM_SIZE_W  = 10;
	localparam int TOM_Z_W     = 8;
	localparam int TOM_REG_W   = 10;
	localparam int TOM_OUT_W   = 13;

	// tile is 8x8 pixels
	localparam int TOM_TILE_SHIFT = 3;
	localparam int TOM_TILE_ROUND = 7;

	// owner code of an unclaimed tile
	localparam logic [TOM_Z_W-1:0] TOM_TILE_EMPTY = 8'hFF;

	// occluded when covered*100/total > 50
	localparam int TOM_PCT_SCALE = 100;
	localparam int TOM_PCT_LIMIT = 50;

	// configuration register reset values
	localparam logic [TOM_REG_W-1:0] TOM_SCREEN_W_RST = 10'd768;
	localparam logic [TOM_REG_W-1:0] TOM_SCREEN_H_RST = 10'd512;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_PAINT = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} tom_command_t;

	typedef enum logic {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} tom_reg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_SPAN,
		ST_BASE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} tom_state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic sweep;
		logic span;
		logic base;
		logic walk;
		logic finish;
	} tom_ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic sweep_last;
		logic span_empty;
		logic walk_last;
		logic out_free;
	} tom_stat_t;

endpackage

// ===== hw/rtl/tile_occlusion_map.sv =====
// ----------------------------------------------------------------------------
// tile_occlusion_map: 8x8-pixel tile owner map with paint and occlusion query
// Clear empties the map, paint claims still-empty tiles for a depth, query
// counts the tiles under a rectangle owned by a nearer depth.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | to block  | in_valid / in_stall  | command, rect_*, layer_z
//   out     | from blk  | out_valid / out_stall| occluded, covered_tiles, area_tiles
//   cfg     | to block  | cfg_we               | cfg_index, cfg_data
//
// Paint and query step through span setup, row base, a tile walk with one tile
// memory access per cycle and a drain state, then load the result; walk and
// drain are skipped when clipping leaves no tile. Clear writes one memory word
// per cycle over the whole map. The next request is taken in the cycle after a
// result is loaded. After reset a clearing pass over all MAP_COLS*MAP_ROWS words
// runs (6144 at the default size); in_stall stays high until it is done. cfg
// writes belong between requests. A stalled result is held in the output
// register while the next request is already accepted and worked on.
// ----------------------------------------------------------------------------
module tile_occlusion_map
	import tom_pkg::*;
#(
	parameter int MAP_COLS = TOM_MAP_COLS,
	parameter int MAP_ROWS = TOM_MAP_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [TOM_REG_W-1:0]          cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    command,
	input  logic signed [TOM_COORD_W-1:0] rect_left,
	input  logic signed [TOM_COORD_W-1:0] rect_top,
	input  logic [TOM_SIZE_W-1:0]         rect_width,
	input  logic [TOM_SIZE_W-1:0]         rect_height,
	input  logic [TOM_Z_W-1:0]            layer_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          occluded,
	output logic [TOM_OUT_W-1:0]          covered_tiles,
	output logic [TOM_OUT_W-1:0]          area_tiles
);

	tom_ctrl_t ctrl;
	tom_stat_t stat;

	// sequencer
	tom_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (command),
		.in_stall   (in_stall),
		.stat       (stat),
		.ctrl       (ctrl)
	);

	// map memory and arithmetic
	tom_datapath #(
		.MAP_COLS (MAP_COLS),
		.MAP_ROWS (MAP_ROWS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.rect_left     (rect_left),
		.rect_top      (rect_top),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.layer_z       (layer_z),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.occluded      (occluded),
		.covered_tiles (covered_tiles),
		.area_tiles    (area_tiles)
	);

endmodule

// ===== hw/rtl/tom_ctrl.sv =====
// ----------------------------------------------------------------------------
// tom_ctrl: command sequencer
// Steps each paint or query through capture, span setup, tile walk and result
// hand-off; runs the clearing sweep after reset and for the clear command.
// ----------------------------------------------------------------------------
module tom_ctrl
	import tom_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [1:0]   in_command,
	output logic         in_stall,
	input  tom_stat_t    stat,
	output tom_ctrl_t    ctrl
);

	tom_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (stat.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (tom_command_t'(in_command))
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_PAINT, CMD_QUERY: state_d = ST_SPAN;
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_CLEAR: begin
				if (stat.sweep_last) state_d = ST_FINISH;
			end
			ST_SPAN: state_d = ST_BASE;
			ST_BASE: begin
				state_d = stat.span_empty ? ST_FINISH : ST_WALK;
			end
			ST_WALK: begin
				if (stat.walk_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_FINISH;
			ST_FINISH: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// outputs
	always_comb begin
		ctrl         = '0;
		in_stall     = (state_q != ST_IDLE);
		ctrl.capture = (state_q == ST_IDLE) && in_valid;
		ctrl.sweep   = (state_q == ST_INIT) || (state_q == ST_CLEAR);
		ctrl.span    = (state_q == ST_SPAN);
		ctrl.base    = (state_q == ST_BASE) && !stat.span_empty;
		ctrl.walk    = (state_q == ST_WALK);
		ctrl.finish  = (state_q == ST_FINISH) && stat.out_free;
	end

	// a result is only loaded into a free output slot
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |-> stat.out_free)
		else $error("result loaded while output slot busy");

	// a walk always ends in the drain state before the result
	a_walk_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.walk && stat.walk_last) |=> (state_q == ST_DRAIN) ##1 (state_q == ST_FINISH))
		else $error("walk did not drain before finish");

	// a new request is never taken while memory work is in flight
	a_capture_alone: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.capture |-> !(ctrl.sweep || ctrl.walk || ctrl.span || ctrl.base))
		else $error("request captured during memory work");

endmodule

// ===== hw/rtl/tom_datapath.sv =====
// ----------------------------------------------------------------------------
// tom_datapath: request registers, span setup, tile memory and counters
// Holds the owner map in a single-port-write, registered-read memory; walks
// tile addresses one per cycle with a one-stage read-modify-write pipe.
// ----------------------------------------------------------------------------
module tom_datapath
	import tom_pkg::*;
#(
	parameter int MAP_COLS = TOM_MAP_COLS,
	parameter int MAP_ROWS = TOM_MAP_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tom_ctrl_t                     ctrl,
	output tom_stat_t                     stat,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [TOM_REG_W-1:0]          cfg_data,
	input  logic [1:0]                    command,
	input  logic signed [TOM_COORD_W-1:0] rect_left,
	input  logic signed [TOM_COORD_W-1:0] rect_top,
	input  logic [TOM_SIZE_W-1:0]         rect_width,
	input  logic [TOM_SIZE_W-1:0]         rect_height,
	input  logic [TOM_Z_W-1:0]            layer_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          occluded,
	output logic [TOM_OUT_W-1:0]          covered_tiles,
	output logic [TOM_OUT_W-1:0]          area_tiles
);

	localparam int DEPTH = MAP_COLS * MAP_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W = $clog2(MAP_COLS + 1);
	localparam int ROW_W = $clog2(MAP_ROWS + 1);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PRD_W = CNT_W + 7;

	localparam logic [AW:0]      COLS_V   = (AW+1)'(MAP_COLS);
	localparam logic [AW-1:0]    LAST_A   = AW'(DEPTH - 1);
	localparam logic [PRD_W-1:0] SCALE_V  = PRD_W'(TOM_PCT_SCALE);
	localparam logic [PRD_W-1:0] THRESH_V = PRD_W'(TOM_PCT_LIMIT + 1);

	// configuration registers
	logic [TOM_REG_W-1:0] screen_w_q, screen_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= TOM_SCREEN_W_RST;
			screen_h_q <= TOM_SCREEN_H_RST;
		end else if (cfg_we) begin
			unique case (tom_reg_t'(cfg_index))
				REG_SCREEN_WIDTH:  screen_w_q <= cfg_data;
				REG_SCREEN_HEIGHT: screen_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	tom_command_t                  cmd_q;
	logic signed [TOM_COORD_W-1:0] left_q, top_q;
	logic [TOM_SIZE_W-1:0]         width_q, height_q;
	logic [TOM_Z_W-1:0]            z_q;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q    <= tom_command_t'(command);
			left_q   <= rect_left;
			top_q    <= rect_top;
			width_q  <= rect_width;
			height_q <= rect_height;
			z_q      <= layer_z;
		end
	end

	// pixel span [lo, hi) clipped, then turned into a tile span within limit
	function automatic logic [15:0] tile_lo(input logic signed [16:0] p, input int limit);
		logic [15:0] t;
		t = {3'b000, p[15:3]};
		if (p < 0) t = '0;
		if (t > 16'(limit)) t = 16'(limit);
		return t;
	endfunction

	function automatic logic [15:0] tile_hi(input logic signed [16:0] p, input int limit);
		logic [16:0] r;
		logic [15:0] t;
		r = {1'b0, p[15:0]} + 17'(TOM_TILE_ROUND);
		t = 16'(r >> TOM_TILE_SHIFT);
		if (p < 0) t = '0;
		if (t > 16'(limit)) t = 16'(limit);
		return t;
	endfunction

	logic signed [16:0] x0, x1, y0, y1, xa, xb, ya, yb, sw, sh;
	logic [15:0]        tx0_w, tx1_w, ty0_w, ty1_w;
	logic               rect_empty, span_empty_w;

	always_comb begin
		x0 = {left_q[15], left_q};
		y0 = {top_q[15], top_q};
		x1 = x0 + $signed({7'b0, width_q});
		y1 = y0 + $signed({7'b0, height_q});
		sw = $signed({7'b0, screen_w_q});
		sh = $signed({7'b0, screen_h_q});
		xa = (x0 < 0) ? 17'sd0 : x0;
		ya = (y0 < 0) ? 17'sd0 : y0;
		xb = x1;
		yb = y1;
		// paint clips to the screen; query only to the map
		if (cmd_q == CMD_PAINT) begin
			if (x1 > sw) xb = sw;
			if (y1 > sh) yb = sh;
			rect_empty = (xa >= xb) || (ya >= yb);
		end else begin
			rect_empty = (width_q == '0) || (height_q == '0);
		end
		tx0_w = tile_lo(xa, MAP_COLS);
		tx1_w = tile_hi(xb, MAP_COLS);
		ty0_w = tile_lo(ya, MAP_ROWS);
		ty1_w = tile_hi(yb, MAP_ROWS);
		span_empty_w = rect_empty || (tx0_w >= tx1_w) || (ty0_w >= ty1_w);
	end

	// registered span
	logic [COL_W-1:0] tx0_q, tx1_q, tx_q;
	logic [ROW_W-1:0] ty0_q, ty1_q, ty_q;
	logic             span_empty_q;
	logic [AW-1:0]    row_base_q;

	always_ff @(posedge clk) begin
		if (ctrl.span) begin
			tx0_q        <= COL_W'(tx0_w);
			tx1_q        <= COL_W'(tx1_w);
			ty0_q        <= ROW_W'(ty0_w);
			ty1_q        <= ROW_W'(ty1_w);
			span_empty_q <= span_empty_w;
		end
	end

	// tile walk: column inner, row outer; row base tracked by addition
	logic          col_last, row_last;
	logic [AW:0]   addr_sum;
	logic [AW-1:0] walk_addr;

	assign col_last  = ((COL_W+1)'(tx_q) + 1'b1) == (COL_W+1)'(tx1_q);
	assign row_last  = ((ROW_W+1)'(ty_q) + 1'b1) == (ROW_W+1)'(ty1_q);
	assign addr_sum  = {1'b0, row_base_q} + (AW+1)'(tx_q);
	assign walk_addr = addr_sum[AW-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.base) begin
			tx_q       <= tx0_q;
			ty_q       <= ty0_q;
			row_base_q <= AW'(ty0_q * MAP_COLS);
		end else if (ctrl.walk) begin
			if (col_last) begin
				tx_q       <= tx0_q;
				ty_q       <= ty_q + 1'b1;
				row_base_q <= AW'({1'b0, row_base_q} + COLS_V);
			end else begin
				tx_q <= tx_q + 1'b1;
			end
		end
	end

	// clearing sweep address
	logic [AW-1:0] sweep_q;
	logic          sweep_last;

	assign sweep_last = (sweep_q == LAST_A);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (ctrl.sweep) begin
			sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
		end
	end

	// read stage
	logic          valid_s1;
	logic [AW-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.walk;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= walk_addr;
	end

	// owner memory
	logic [TOM_Z_W-1:0] owner_mem [DEPTH];
	logic [TOM_Z_W-1:0] rd_data_q;
	logic               paint_we, mem_we;
	logic [AW-1:0]      wr_addr;
	logic [TOM_Z_W-1:0] wr_data;

	assign paint_we = valid_s1 && (cmd_q == CMD_PAINT) && (rd_data_q == TOM_TILE_EMPTY);
	assign mem_we   = ctrl.sweep || paint_we;
	assign wr_addr  = ctrl.sweep ? sweep_q : addr_s1;
	assign wr_data  = ctrl.sweep ? TOM_TILE_EMPTY : z_q;

	always_ff @(posedge clk) begin
		if (mem_we) owner_mem[wr_addr] <= wr_data;
		rd_data_q <= owner_mem[walk_addr];
	end

	// query counters
	logic [CNT_W-1:0] covered_q, total_q;
	logic             count_en;

	assign count_en = valid_s1 && (cmd_q == CMD_QUERY);

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			covered_q <= '0;
			total_q   <= '0;
		end else if (count_en) begin
			total_q <= total_q + 1'b1;
			if (rd_data_q < z_q) covered_q <= covered_q + 1'b1;
		end
	end

	// occluded when 100*covered >= 51*total (integer percent above half)
	logic [PRD_W-1:0] cov_scaled, tot_scaled;
	logic             occ_w;

	assign cov_scaled = PRD_W'(covered_q) * SCALE_V;
	assign tot_scaled = PRD_W'(total_q) * THRESH_V;
	assign occ_w      = (total_q != '0) && (cov_scaled >= tot_scaled);

	// output register
	logic                 out_valid_q, occ_q;
	logic [TOM_OUT_W-1:0] cov_out_q, tot_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			occ_q     <= occ_w;
			cov_out_q <= TOM_OUT_W'(covered_q);
			tot_out_q <= TOM_OUT_W'(total_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign occluded      = occ_q;
	assign covered_tiles = cov_out_q;
	assign area_tiles    = tot_out_q;

	// status
	always_comb begin
		stat            = '0;
		stat.sweep_last = sweep_last;
		stat.span_empty = span_empty_q;
		stat.walk_last  = col_last && row_last;
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// walk never leaves the map
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.walk |-> (addr_sum < (AW+1)'(DEPTH)))
		else $error("tile address outside map");

	// sweep and paint write-back never compete for the write port
	a_wr_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.sweep && valid_s1))
		else $error("sweep overlaps tile walk");

	// the covered count can never pass the total count
	a_cnt_order: assert property (@(posedge clk) disable iff (!arst_n)
		$past(count_en) |-> (covered_q <= total_q))
		else $error("covered count exceeds total");

endmodule
